[rtl/bmt_pkg.sv]
// Shared constants and helpers for the baseline match table.
`timescale 1ns / 1ps
package bmt_pkg;
    localparam int COORD_W = 31;
    localparam int VAL_W = 32;
    localparam int WAVE_W = 32;
    localparam int TOL_W = 32;
    localparam int IDX_W = 10;
    localparam int PROD_W = 64;
    localparam int RHS_W = 96;
    localparam int LHS_SHIFT = 41;
    localparam int CMP_W = PROD_W + LHS_SHIFT;
    localparam int ENTRY_W = 2 * VAL_W + WAVE_W;
    localparam int TABLE_DEPTH_DEF = 1024;
    localparam logic [TOL_W-1:0] TOL_RESET = 32'd2749;
    localparam logic CMD_POWER = 1'b0;
    localparam logic CMD_TRIANGLE = 1'b1;

    function automatic logic [VAL_W-1:0] mag33(input logic signed [VAL_W:0] x);
        logic signed [VAL_W:0] t;
        begin
            t = x[VAL_W] ? -x : x;
            mag33 = t[VAL_W-1:0];
        end
    endfunction
endpackage

[rtl/bmt_ram.sv]
// Simple dual-port RAM with registered read.
`timescale 1ns / 1ps
module bmt_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

[rtl/bmt_mul.sv]
// Shared 32x32 unsigned multiplier with registered product.
`timescale 1ns / 1ps
module bmt_mul (
    input  logic                        clk,
    input  logic [bmt_pkg::VAL_W-1:0]   op_a,
    input  logic [bmt_pkg::VAL_W-1:0]   op_b,
    output logic [bmt_pkg::PROD_W-1:0]  prod
);
    import bmt_pkg::*;

    always_ff @(posedge clk)
    begin
        prod <= PROD_W'(op_a) * PROD_W'(op_b);
    end
endmodule

[rtl/baseline_match_table.sv]
// Top level: table sequencer, entry RAM, shared multiplier and result register.
// Power item: start leads to the insert state, which fires the registered result strobe.
// Triangle item: for each of three baselines, the stored entries are scanned; an entry of equal
// wavelength is compared on the shared multiplier, others are skipped. busy holds meanwhile.
// Reset empties the table (count one, entry zero reserved) and loads tol_reg with 2749.
// Results go out for one cycle each on result_valid; the receiver cannot stall.
`timescale 1ns / 1ps
module baseline_match_table #(
    parameter int TABLE_DEPTH = bmt_pkg::TABLE_DEPTH_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic                               cmd,
    input  logic signed [bmt_pkg::COORD_W-1:0] u_first,
    input  logic signed [bmt_pkg::COORD_W-1:0] v_first,
    input  logic signed [bmt_pkg::COORD_W-1:0] u_second,
    input  logic signed [bmt_pkg::COORD_W-1:0] v_second,
    input  logic [bmt_pkg::WAVE_W-1:0]         wave_code,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [bmt_pkg::TOL_W-1:0]          cfg_data,
    output logic                               result_valid,
    output logic [bmt_pkg::IDX_W-1:0]          entry_index,
    output logic                               negated,
    output logic                               created,
    output logic                               full_res,
    output logic                               last
);
    import bmt_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam logic signed [VAL_W:0] SUM_MIN = {2'b11, {(VAL_W-1){1'b0}}};
    localparam logic signed [VAL_W-1:0] SAT_POS = {1'b0, {(VAL_W-1){1'b1}}};

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCAN   = 3'd1;
    localparam logic [2:0] S_CHECK  = 3'd2;
    localparam logic [2:0] S_COMP   = 3'd3;
    localparam logic [2:0] S_DECIDE = 3'd4;
    localparam logic [2:0] S_INSERT = 3'd5;

    logic [2:0] state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] scan_reg, scan_next;
    logic [1:0] base_reg, base_next;
    logic comp_reg, comp_next;
    logic [2:0] phase_reg, phase_next;
    logic [1:0] pass_d_reg, pass_d_next;
    logic [1:0] pass_c_reg, pass_c_next;
    logic [TOL_W-1:0] tol_reg;
    logic cmd_reg;
    logic signed [VAL_W-1:0] u1_reg, v1_reg, u2_reg, v2_reg, u3_reg, v3_reg;
    logic [WAVE_W-1:0] wave_reg;
    logic [PROD_W-1:0] s_reg, s_next;
    logic [RHS_W-1:0] rhs_reg, rhs_next;

    logic signed [VAL_W-1:0] cur_u, cur_v, cur_a, tab_b, tab_u, tab_v;
    logic signed [VAL_W-1:0] u3_in, v3_in, ins_u, ins_v;
    logic signed [VAL_W:0] sum_u, sum_v;
    logic [VAL_W-1:0] ma, mb, mdd, mdc, op_a, op_b;
    logic [PROD_W-1:0] prod;
    logic [ENTRY_W-1:0] rd_data, wr_data;
    logic [WAVE_W-1:0] tab_w;
    logic we;
    logic test_pass;
    logic res_fire, res_neg, res_created, res_full, res_last;
    logic [CW-1:0] res_idx;

    assign busy = (state_reg != S_IDLE);
    assign cfg_ready = !busy;

    assign sum_u = (VAL_W+1)'(u_first) + (VAL_W+1)'(u_second);
    assign sum_v = (VAL_W+1)'(v_first) + (VAL_W+1)'(v_second);
    assign u3_in = (sum_u == SUM_MIN) ? SAT_POS : VAL_W'(-sum_u);
    assign v3_in = (sum_v == SUM_MIN) ? SAT_POS : VAL_W'(-sum_v);

    always_comb
    begin
        case (base_reg)
            2'd0:
            begin
                cur_u = u1_reg;
                cur_v = v1_reg;
            end
            2'd1:
            begin
                cur_u = u2_reg;
                cur_v = v2_reg;
            end
            default:
            begin
                cur_u = u3_reg;
                cur_v = v3_reg;
            end
        endcase
    end

    assign tab_u = rd_data[ENTRY_W-1 -: VAL_W];
    assign tab_v = rd_data[ENTRY_W-VAL_W-1 -: VAL_W];
    assign tab_w = rd_data[WAVE_W-1:0];
    assign cur_a = comp_reg ? cur_v : cur_u;
    assign tab_b = comp_reg ? tab_v : tab_u;
    assign ma = mag33((VAL_W+1)'(cur_a));
    assign mb = mag33((VAL_W+1)'(tab_b));
    assign mdd = mag33((VAL_W+1)'(cur_a) - (VAL_W+1)'(tab_b));
    assign mdc = mag33((VAL_W+1)'(cur_a) + (VAL_W+1)'(tab_b));

    always_comb
    begin
        case (phase_reg)
            3'd1:
            begin
                op_a = mb;
                op_b = mb;
            end
            3'd3:
            begin
                op_a = tol_reg;
                op_b = s_reg[VAL_W-1:0];
            end
            3'd4:
            begin
                op_a = tol_reg;
                op_b = s_reg[PROD_W-1:VAL_W];
            end
            3'd5:
            begin
                op_a = mdd;
                op_b = mdd;
            end
            3'd6:
            begin
                op_a = mdc;
                op_b = mdc;
            end
            default:
            begin
                op_a = ma;
                op_b = ma;
            end
        endcase
    end

    bmt_mul u_mul (
        .clk  (clk),
        .op_a (op_a),
        .op_b (op_b),
        .prod (prod)
    );

    always_comb
    begin
        if ((phase_reg == 3'd6) ? (mdd == '0) : (mdc == '0))
        begin
            test_pass = (tol_reg != '0);
        end
        else
        begin
            test_pass = ({prod, {LHS_SHIFT{1'b0}}} < CMP_W'(rhs_reg));
        end
    end

    assign ins_u = cur_u[VAL_W-1] ? -cur_u : cur_u;
    assign ins_v = cur_u[VAL_W-1] ? -cur_v : cur_v;
    assign wr_data = {ins_u, ins_v, wave_reg};
    assign we = (state_reg == S_INSERT) && (count_reg != CW'(TABLE_DEPTH));

    bmt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (count_reg[AW-1:0]),
        .wdata (wr_data),
        .raddr (scan_reg[AW-1:0]),
        .rdata (rd_data)
    );

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        scan_next = scan_reg;
        base_next = base_reg;
        comp_next = comp_reg;
        phase_next = phase_reg;
        pass_d_next = pass_d_reg;
        pass_c_next = pass_c_reg;
        s_next = s_reg;
        rhs_next = rhs_reg;
        res_fire = 1'b0;
        res_neg = 1'b0;
        res_created = 1'b0;
        res_full = 1'b0;
        res_idx = scan_reg;
        res_last = (cmd_reg == CMD_POWER) || (base_reg == 2'd2);
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    base_next = 2'd0;
                    scan_next = CW'(1);
                    state_next = (cmd == CMD_TRIANGLE) ? S_SCAN : S_INSERT;
                end
            end
            S_SCAN:
            begin
                state_next = (scan_reg >= count_reg) ? S_INSERT : S_CHECK;
            end
            S_CHECK:
            begin
                if (tab_w != wave_reg)
                begin
                    scan_next = scan_reg + CW'(1);
                    state_next = S_SCAN;
                end
                else
                begin
                    comp_next = 1'b0;
                    phase_next = 3'd0;
                    state_next = S_COMP;
                end
            end
            S_COMP:
            begin
                phase_next = phase_reg + 3'd1;
                case (phase_reg)
                    3'd1: s_next = prod;
                    3'd2: s_next = s_reg + prod;
                    3'd4: rhs_next = RHS_W'(prod);
                    3'd5: rhs_next = rhs_reg + {prod, {VAL_W{1'b0}}};
                    3'd6: pass_d_next[comp_reg] = test_pass;
                    3'd7:
                    begin
                        pass_c_next[comp_reg] = test_pass;
                        comp_next = 1'b1;
                        if (comp_reg)
                        begin
                            state_next = S_DECIDE;
                        end
                    end
                    default: ;
                endcase
            end
            S_DECIDE:
            begin
                if ((pass_d_reg == 2'b11) || (pass_c_reg == 2'b11))
                begin
                    res_fire = 1'b1;
                    res_neg = (pass_d_reg != 2'b11);
                end
                else
                begin
                    scan_next = scan_reg + CW'(1);
                    state_next = S_SCAN;
                end
            end
            S_INSERT:
            begin
                res_fire = 1'b1;
                if (count_reg == CW'(TABLE_DEPTH))
                begin
                    res_full = 1'b1;
                    res_idx = '0;
                end
                else
                begin
                    res_idx = count_reg;
                    res_neg = cur_u[VAL_W-1];
                    res_created = 1'b1;
                    count_next = count_reg + CW'(1);
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        if (res_fire)
        begin
            if (res_last)
            begin
                state_next = S_IDLE;
            end
            else
            begin
                base_next = base_reg + 2'd1;
                scan_next = CW'(1);
                state_next = S_SCAN;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= CW'(1);
            scan_reg <= CW'(1);
            base_reg <= 2'd0;
            comp_reg <= 1'b0;
            phase_reg <= 3'd0;
            pass_d_reg <= 2'b00;
            pass_c_reg <= 2'b00;
            tol_reg <= TOL_RESET;
            result_valid <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            scan_reg <= scan_next;
            base_reg <= base_next;
            comp_reg <= comp_next;
            phase_reg <= phase_next;
            pass_d_reg <= pass_d_next;
            pass_c_reg <= pass_c_next;
            if (cfg_valid && cfg_ready)
            begin
                tol_reg <= cfg_data;
            end
            result_valid <= res_fire;
        end
    end

    always_ff @(posedge clk)
    begin
        s_reg <= s_next;
        rhs_reg <= rhs_next;
        if (start && !busy)
        begin
            cmd_reg <= cmd;
            u1_reg <= VAL_W'(u_first);
            v1_reg <= VAL_W'(v_first);
            u2_reg <= VAL_W'(u_second);
            v2_reg <= VAL_W'(v_second);
            u3_reg <= u3_in;
            v3_reg <= v3_in;
            wave_reg <= wave_code;
        end
        if (res_fire)
        begin
            entry_index <= IDX_W'(res_idx);
            negated <= res_neg;
            created <= res_created;
            full_res <= res_full;
            last <= res_last;
        end
    end

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != '0) && (count_reg <= CW'(TABLE_DEPTH)))
        else $error("entry count out of range");

    a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(busy))
        else $error("result without work in progress");

    a_created_grow: assert property (@(posedge clk) disable iff (!rst_n)
        (res_fire && res_created) |=> (count_reg == $past(count_reg) + CW'(1)))
        else $error("insert did not advance count");

    a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !(created && full_res))
        else $error("created and full together");
endmodule
